>>> rtl/core/pedo_pkg.sv
// Package for the pedometer step and pace detector.
// Shared constants, register indexes and the sequencer state type. No dependencies.
package pedo_pkg;

    localparam int unsigned STEP_SLOTS_DEF      = 256;
    localparam int unsigned WINDOW_MS_DEF       = 60000;
    localparam int unsigned IDLE_TIMEOUT_MS_DEF = 2000;
    localparam int unsigned STARTUP_WAIT_MS_DEF = 3000;

    localparam logic [26:0] LOW_SQ_Q24  = 27'd28353496;
    localparam logic [27:0] HIGH_SQ_Q24 = 28'd205520896;
    localparam logic [15:0] DWELL_MIN_MS = 16'd30;
    localparam logic [15:0] DWELL_MAX_MS = 16'd250;
    localparam logic [31:0] GAP_MS       = 32'd250;
    localparam logic [15:0] DWELL_CAP    = 16'hFFFF;

    localparam logic [1:0] PACE_IDLE = 2'd0;
    localparam logic [1:0] PACE_WALK = 2'd1;
    localparam logic [1:0] PACE_RUN  = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_OFFSET_X  = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z  = 3'd2;
    localparam logic [2:0] REG_INV_GAIN_X = 3'd3;
    localparam logic [2:0] REG_INV_GAIN_Y = 3'd4;
    localparam logic [2:0] REG_INV_GAIN_Z = 3'd5;
    localparam logic [2:0] REG_RUN_MS    = 3'd6;
    localparam logic [2:0] REG_WALK_MS   = 3'd7;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_AXIS  = 7'b0000010,
        ST_SQR   = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_TAIL  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } seq_state_t;

endpackage

>>> rtl/core/pedometer_step_and_pace_detector_top.sv
// Top level of the pedometer step and pace detector: APB registers and stream ports.
// Depends on pedo_pkg and pedo_ctrl.
//
//  channel | direction | word
//  s_      | in        | tdata: raw_x, raw_y, raw_z, time_ms
//  m_      | out       | tdata: step_seen, step_total, pace, steps_last_minute
//  apb     | in        | eight registers at 4*i
//
// m_tvalid rises after the states AXIS, SQR, DECIDE, SCAN and TAIL; the next word
// is taken only once the result has been taken.
// The ring scan reads one slot a cycle from the single read port.
// Reset is synchronous, active low; the ring needs no clearing pass.
// The block is not ready while a sample is at work or its result waits.
module pedometer_step_and_pace_detector_top
    import pedo_pkg::*;
#(
    parameter int unsigned STEP_SLOTS      = STEP_SLOTS_DEF,
    parameter int unsigned WINDOW_MS       = WINDOW_MS_DEF,
    parameter int unsigned IDLE_TIMEOUT_MS = IDLE_TIMEOUT_MS_DEF,
    parameter int unsigned STARTUP_WAIT_MS = STARTUP_WAIT_MS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // raw_x[11:0], raw_y[23:12], raw_z[35:24], time_ms[67:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // step_seen[0], step_total[32:1], pace[34:33], slm[43:35]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] offx_reg, offy_reg, offz_reg;
    logic [23:0] gx_reg, gy_reg, gz_reg;
    logic [15:0] run_reg, walk_reg;
    logic [2:0]  ridx;
    logic        wr;

    logic        step_seen;
    logic [31:0] step_total;
    logic [1:0]  pace;
    logic [8:0]  slm;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offx_reg <= 13'd4096; offy_reg <= 13'd4096; offz_reg <= 13'd4096;
            gx_reg <= 24'd41943; gy_reg <= 24'd41943; gz_reg <= 24'd41943;
            run_reg <= 16'd400; walk_reg <= 16'd700;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (ridx)
                REG_OFFSET_X:   offx_reg <= pwdata[12:0];
                REG_OFFSET_Y:   offy_reg <= pwdata[12:0];
                REG_OFFSET_Z:   offz_reg <= pwdata[12:0];
                REG_INV_GAIN_X: gx_reg   <= pwdata[23:0];
                REG_INV_GAIN_Y: gy_reg   <= pwdata[23:0];
                REG_INV_GAIN_Z: gz_reg   <= pwdata[23:0];
                REG_RUN_MS:     run_reg  <= pwdata[15:0];
                REG_WALK_MS:    walk_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (ridx)
            REG_OFFSET_X:   prdata = {19'b0, offx_reg};
            REG_OFFSET_Y:   prdata = {19'b0, offy_reg};
            REG_OFFSET_Z:   prdata = {19'b0, offz_reg};
            REG_INV_GAIN_X: prdata = {8'b0, gx_reg};
            REG_INV_GAIN_Y: prdata = {8'b0, gy_reg};
            REG_INV_GAIN_Z: prdata = {8'b0, gz_reg};
            REG_RUN_MS:     prdata = {16'b0, run_reg};
            REG_WALK_MS:    prdata = {16'b0, walk_reg};
            default:        prdata = '0;
        endcase
    end

    pedo_ctrl #(
        .STEP_SLOTS      (STEP_SLOTS),
        .WINDOW_MS       (WINDOW_MS),
        .IDLE_TIMEOUT_MS (IDLE_TIMEOUT_MS),
        .STARTUP_WAIT_MS (STARTUP_WAIT_MS)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .raw_x             (s_tdata[11:0]),
        .raw_y             (s_tdata[23:12]),
        .raw_z             (s_tdata[35:24]),
        .time_ms           (s_tdata[67:36]),
        .offset_x          (offx_reg),
        .offset_y          (offy_reg),
        .offset_z          (offz_reg),
        .inv_gain_x        (gx_reg),
        .inv_gain_y        (gy_reg),
        .inv_gain_z        (gz_reg),
        .run_interval_ms   (run_reg),
        .walk_interval_ms  (walk_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .step_seen         (step_seen),
        .step_total        (step_total),
        .pace              (pace),
        .steps_last_minute (slm)
    );

    assign m_tdata = {4'b0, slm, pace, step_total, step_seen};

endmodule

>>> rtl/core/pedo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pedo_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/pedo_axis_unit.sv
// Shared scaling and squaring unit: one axis per pass, accumulates the sum of squares.
// Depends on pedo_pkg.
module pedo_axis_unit
    import pedo_pkg::*;
(
    input  logic        aclk,
    input  logic        clr,       // start of a new sample
    input  logic        scale_en,  // register the scaled magnitude
    input  logic        sqr_en,    // add its square to the sum
    input  logic [11:0] raw,
    input  logic [12:0] offset,
    input  logic [23:0] inv_gain,
    output logic [31:0] sum_sq
);

    logic [13:0] twice;
    logic        neg;
    logic [13:0] d_abs;
    logic [37:0] prod;
    logic [24:0] q;
    logic [15:0] mag_next;
    logic [15:0] mag_reg;
    logic [31:0] sq;
    logic [31:0] sum_reg;      // three squares of up to 2^30 need the full 32 bits

    // |2*raw - offset| * gain, rounded, saturated
    always_comb begin
        twice = {1'b0, raw, 1'b0};
        neg   = twice < {1'b0, offset};
        d_abs = neg ? ({1'b0, offset} - twice) : (twice - {1'b0, offset});
        prod  = d_abs * inv_gain;
        q     = 25'((prod + 38'd4096) >> 13);
        if (neg) begin
            mag_next = (q > 25'd32768) ? 16'd32768 : q[15:0];
        end else begin
            mag_next = (q > 25'd32767) ? 16'd32767 : q[15:0];
        end
    end

    assign sq = mag_reg * mag_reg;

    always_ff @(posedge aclk) begin
        if (scale_en) begin
            mag_reg <= mag_next;
        end
        if (clr) begin
            sum_reg <= '0;
        end else if (sqr_en) begin
            sum_reg <= sum_reg + sq;
        end
    end

    assign sum_sq = sum_reg;

endmodule

>>> rtl/core/pedo_ctrl.sv
// Sequencer: runs the axis unit and step decision, then scans the step ring and updates the pace.
// Depends on pedo_pkg, pedo_axis_unit, pedo_ram.
module pedo_ctrl
    import pedo_pkg::*;
#(
    parameter int unsigned STEP_SLOTS      = STEP_SLOTS_DEF,
    parameter int unsigned WINDOW_MS       = WINDOW_MS_DEF,
    parameter int unsigned IDLE_TIMEOUT_MS = IDLE_TIMEOUT_MS_DEF,
    parameter int unsigned STARTUP_WAIT_MS = STARTUP_WAIT_MS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] raw_x,
    input  logic [11:0] raw_y,
    input  logic [11:0] raw_z,
    input  logic [31:0] time_ms,
    input  logic [12:0] offset_x,
    input  logic [12:0] offset_y,
    input  logic [12:0] offset_z,
    input  logic [23:0] inv_gain_x,
    input  logic [23:0] inv_gain_y,
    input  logic [23:0] inv_gain_z,
    input  logic [15:0] run_interval_ms,
    input  logic [15:0] walk_interval_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        step_seen,
    output logic [31:0] step_total,
    output logic [1:0]  pace,
    output logic [8:0]  steps_last_minute
);

    localparam int unsigned AW = $clog2(STEP_SLOTS);
    localparam int unsigned CW = $clog2(STEP_SLOTS + 1);

    seq_state_t state_reg, state_next;

    logic [11:0] rx_reg, ry_reg, rz_reg;
    logic [31:0] now_reg;
    logic [1:0]  axis_reg;
    logic        phase_reg;   // 0 scale, 1 square
    logic [AW:0] scan_reg;    // read address counter, can hold depth
    logic [AW:0] vcnt_reg;    // data-valid lag for the registered read
    logic [CW-1:0] count_reg;
    logic [AW:0] filled_reg;  // slots ever written, since ring fills in order

    logic        in_window_reg;
    logic [15:0] dwell_reg;
    logic [31:0] mark_reg, last_reg, newest_reg, prev_reg, total_reg;
    logic [AW-1:0] ptr_reg;
    logic [1:0]  pace_reg;
    logic        seen_reg;

    logic [11:0] raw_sel;
    logic [12:0] off_sel;
    logic [23:0] gain_sel;
    logic [31:0] sum_sq;
    logic        clr, scale_en, sqr_en;

    logic        ram_we;
    logic [31:0] ram_rdata;
    logic        rd_ok;

    // input handshake
    assign in_ready = state_reg == ST_IDLE;
    assign clr      = in_valid && in_ready;

    always_comb begin
        case (axis_reg)
            2'd0:    begin raw_sel = rx_reg; off_sel = offset_x; gain_sel = inv_gain_x; end
            2'd1:    begin raw_sel = ry_reg; off_sel = offset_y; gain_sel = inv_gain_y; end
            default: begin raw_sel = rz_reg; off_sel = offset_z; gain_sel = inv_gain_z; end
        endcase
    end

    assign scale_en = (state_reg == ST_AXIS) && !phase_reg;
    assign sqr_en   = (state_reg == ST_AXIS) && phase_reg;

    pedo_axis_unit u_axis (
        .aclk     (aclk),
        .clr      (clr),
        .scale_en (scale_en),
        .sqr_en   (sqr_en),
        .raw      (raw_sel),
        .offset   (off_sel),
        .inv_gain (gain_sel),
        .sum_sq   (sum_sq)
    );

    // step decision terms
    logic        mag_hit;
    logic [32:0] dwell_acc;
    logic        take_step;
    logic [31:0] interval, since_newest;
    assign mag_hit   = (sum_sq >= {5'b0, LOW_SQ_Q24}) &&
                       (sum_sq <= {4'b0, HIGH_SQ_Q24});
    assign dwell_acc = {17'b0, dwell_reg} + {1'b0, now_reg - mark_reg};
    assign take_step = !mag_hit && in_window_reg && dwell_reg >= DWELL_MIN_MS &&
                       dwell_reg <= DWELL_MAX_MS && (now_reg - last_reg) > GAP_MS;
    assign interval     = newest_reg - prev_reg;
    assign since_newest = now_reg - newest_reg;

    assign ram_we = (state_reg == ST_DECIDE) && take_step;

    pedo_ram #(.WIDTH(32), .DEPTH(STEP_SLOTS)) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (now_reg),
        .raddr (scan_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // slot only counts once written; unwritten slots read as empty
    assign rd_ok = vcnt_reg < filled_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_AXIS;
            ST_AXIS:   if (phase_reg && axis_reg == 2'd2) state_next = ST_SQR;
            ST_SQR:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_SCAN;
            ST_SCAN:   if (scan_reg == (AW+1)'(STEP_SLOTS - 1)) state_next = ST_TAIL;
            ST_TAIL:   state_next = ST_OUT;
            ST_OUT:    if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            phase_reg     <= 1'b0;
            scan_reg      <= '0;
            vcnt_reg      <= '0;
            count_reg     <= '0;
            filled_reg    <= '0;
            in_window_reg <= 1'b0;
            dwell_reg     <= '0;
            mark_reg      <= '0;
            last_reg      <= '0;
            newest_reg    <= '0;
            prev_reg      <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            pace_reg      <= PACE_IDLE;
            seen_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        rx_reg    <= raw_x;
                        ry_reg    <= raw_y;
                        rz_reg    <= raw_z;
                        now_reg   <= time_ms;
                        axis_reg  <= '0;
                        phase_reg <= 1'b0;
                    end
                end
                ST_AXIS: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) axis_reg <= axis_reg + 2'd1;
                end
                ST_SQR: begin
                    // window entry and dwell; exit is handled with the step decision
                    seen_reg <= 1'b0;
                    if (mag_hit) begin
                        if (!in_window_reg) dwell_reg <= '0;
                        else dwell_reg <= (dwell_acc > {17'b0, DWELL_CAP}) ?
                                          DWELL_CAP : dwell_acc[15:0];
                        mark_reg      <= now_reg;
                        in_window_reg <= 1'b1;
                    end
                end
                ST_DECIDE: begin
                    if (take_step) begin
                        prev_reg   <= newest_reg;
                        newest_reg <= now_reg;
                        last_reg   <= now_reg;
                        ptr_reg    <= (ptr_reg == AW'(STEP_SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
                        total_reg  <= total_reg + 32'd1;
                        seen_reg   <= 1'b1;
                        if (filled_reg != (AW+1)'(STEP_SLOTS)) filled_reg <= filled_reg + 1'b1;
                    end
                    // window exit
                    if (!mag_hit && in_window_reg) begin
                        in_window_reg <= 1'b0;
                        dwell_reg     <= '0;
                    end
                    scan_reg  <= '0;
                    count_reg <= '0;
                end
                ST_SCAN: begin
                    scan_reg <= scan_reg + 1'b1;
                    vcnt_reg <= scan_reg;
                    if (scan_reg != '0 && rd_ok && ram_rdata != '0 &&
                        (now_reg - ram_rdata) <= 32'(WINDOW_MS)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    // pace update, ring state already settled
                    if (scan_reg == '0 && newest_reg != '0 && prev_reg != '0 &&
                        now_reg > 32'(STARTUP_WAIT_MS)) begin
                        if (since_newest > 32'(IDLE_TIMEOUT_MS)) pace_reg <= PACE_IDLE;
                        else if (interval <= {16'b0, run_interval_ms}) pace_reg <= PACE_RUN;
                        else if (interval <= {16'b0, walk_interval_ms}) pace_reg <= PACE_WALK;
                    end
                end
                ST_TAIL: begin
                    vcnt_reg <= scan_reg;
                    if (rd_ok && ram_rdata != '0 &&
                        (now_reg - ram_rdata) <= 32'(WINDOW_MS)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    assign out_valid  = state_reg == ST_OUT;
    assign step_seen  = seen_reg;
    assign step_total = total_reg;
    assign pace       = pace_reg;
    assign steps_last_minute = (count_reg > CW'(511)) ? 9'd511 : 9'(count_reg);

    // a result is held until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(step_total))
        else $error("result dropped under stall");
    // no input taken while a sample is at work
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("ready while busy");
    // step total moves only with a step flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != $past(total_reg) |-> seen_reg)
        else $error("count moved without a step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        pace_reg != 2'd3)
        else $error("bad pace code");

endmodule
